// ----- rtl/core/sps_pkg.sv -----
package sps_pkg;

  // default grid side
  localparam int GRID_SIDE_DEF = 64;

  // request modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_SWEEP = 2'd2;

  // input request
  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [5:0]  row_end;
    logic [5:0]  col_end;
    logic [31:0] cell_value;
  } in_item_t;

  // result
  typedef struct packed {
    logic [31:0] read_value;
    logic        changed;
  } out_item_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LOAD,
    ST_RD,
    ST_RD_WAIT,
    ST_RD_CTR,
    ST_CHK_CTR,
    ST_RD_NB,
    ST_UPD_NB,
    ST_NEXT,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/core/sps_ram.sv -----
module sps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/sps_ctrl.sv -----
module sps_ctrl #(
  parameter int GRID_SIDE = sps_pkg::GRID_SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  sps_pkg::in_item_t item,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output sps_pkg::out_item_t res
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int XW    = (CW > 6) ? CW + 1 : 7;

  // raise to 1, lower to side-1
  function automatic logic [CW-1:0] clamp_coord(input logic [5:0] v);
    logic [XW-1:0] x;
    x = XW'(v);
    if (x < XW'(1)) x = XW'(1);
    if (x > XW'(GRID_SIDE - 1)) x = XW'(GRID_SIDE - 1);
    return x[CW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(GRID_SIDE) + AW'(c);
  endfunction

  sps_pkg::state_t state_r, state_nxt;
  sps_pkg::in_item_t item_r;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] r_r, r_nxt, c_r, c_nxt;
  logic [CW-1:0] re_r, re_nxt, cs_r, cs_nxt, ce_r, ce_nxt;
  logic [29:0]   q_r, q_nxt;
  logic [1:0]    nb_r, nb_nxt;
  logic          any_r, any_nxt;
  logic [31:0]   rd_r, rd_nxt;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr, nb_addr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic [31:0]   sum;
  logic          in_grid;
  logic [CW-1:0] rs_c, re_c, cs_c, ce_c;

  sps_ram #(.WIDTH(32), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // request cell inside the grid
  assign in_grid = (XW'(item_r.row) < XW'(GRID_SIDE)) && (XW'(item_r.col) < XW'(GRID_SIDE));

  // clamped window
  assign rs_c = clamp_coord(item_r.row);
  assign re_c = clamp_coord(item_r.row_end);
  assign cs_c = clamp_coord(item_r.col);
  assign ce_c = clamp_coord(item_r.col_end);

  // neighbour address: left, right, up, down
  always_comb begin
    unique case (nb_r)
      2'd0:    nb_addr = addr_r - AW'(1);
      2'd1:    nb_addr = addr_r + AW'(1);
      2'd2:    nb_addr = addr_r - AW'(GRID_SIDE);
      default: nb_addr = addr_r + AW'(GRID_SIDE);
    endcase
  end

  // shared adder for neighbour updates
  assign sum = mem_rdata + {2'b00, q_r};

  // request register
  always_ff @(posedge clk) begin
    if (start) begin
      item_r <= item;
    end
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    addr_r <= addr_nxt;
    r_r    <= r_nxt;
    c_r    <= c_nxt;
    re_r   <= re_nxt;
    cs_r   <= cs_nxt;
    ce_r   <= ce_nxt;
    q_r    <= q_nxt;
    nb_r   <= nb_nxt;
    any_r  <= any_nxt;
    rd_r   <= rd_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    re_nxt    = re_r;
    cs_nxt    = cs_r;
    ce_nxt    = ce_r;
    q_nxt     = q_r;
    nb_nxt    = nb_r;
    any_nxt   = any_r;
    rd_nxt    = rd_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr_r;
    mem_wdata = item_r.cell_value;
    idle      = 1'b0;
    res_valid = 1'b0;

    unique case (state_r)
      sps_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (start) state_nxt = sps_pkg::ST_SETUP;
      end
      sps_pkg::ST_SETUP: begin
        rd_nxt   = '0;
        any_nxt  = 1'b0;
        addr_nxt = addr_of(CW'(item_r.row), CW'(item_r.col));
        priority if (item_r.mode == sps_pkg::MODE_LOAD) begin
          state_nxt = in_grid ? sps_pkg::ST_LOAD : sps_pkg::ST_DONE;
        end else if (item_r.mode == sps_pkg::MODE_READ) begin
          state_nxt = in_grid ? sps_pkg::ST_RD : sps_pkg::ST_DONE;
        end else if (item_r.mode == sps_pkg::MODE_SWEEP) begin
          r_nxt    = rs_c;
          c_nxt    = cs_c;
          re_nxt   = re_c;
          cs_nxt   = cs_c;
          ce_nxt   = ce_c;
          addr_nxt = addr_of(rs_c, cs_c);
          // empty window changes nothing
          if (rs_c < re_c && cs_c < ce_c) state_nxt = sps_pkg::ST_RD_CTR;
          else                            state_nxt = sps_pkg::ST_DONE;
        end else begin
          state_nxt = sps_pkg::ST_DONE;
        end
      end
      sps_pkg::ST_LOAD: begin
        mem_we    = 1'b1;
        state_nxt = sps_pkg::ST_DONE;
      end
      sps_pkg::ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = sps_pkg::ST_RD_WAIT;
      end
      sps_pkg::ST_RD_WAIT: begin
        rd_nxt    = mem_rdata;
        state_nxt = sps_pkg::ST_DONE;
      end
      sps_pkg::ST_RD_CTR: begin
        mem_re    = 1'b1;
        state_nxt = sps_pkg::ST_CHK_CTR;
      end
      sps_pkg::ST_CHK_CTR: begin
        // topple: keep remainder, spread quotient
        if (mem_rdata[31:2] != '0) begin
          mem_we    = 1'b1;
          mem_wdata = {30'd0, mem_rdata[1:0]};
          q_nxt     = mem_rdata[31:2];
          any_nxt   = 1'b1;
          nb_nxt    = 2'd0;
          state_nxt = sps_pkg::ST_RD_NB;
        end else begin
          state_nxt = sps_pkg::ST_NEXT;
        end
      end
      sps_pkg::ST_RD_NB: begin
        mem_re    = 1'b1;
        mem_addr  = nb_addr;
        state_nxt = sps_pkg::ST_UPD_NB;
      end
      sps_pkg::ST_UPD_NB: begin
        mem_we    = 1'b1;
        mem_addr  = nb_addr;
        mem_wdata = sum;
        nb_nxt    = nb_r + 2'd1;
        state_nxt = (nb_r == 2'd3) ? sps_pkg::ST_NEXT : sps_pkg::ST_RD_NB;
      end
      sps_pkg::ST_NEXT: begin
        // row-major advance through the window
        priority if ({1'b0, c_r} + 1'b1 < {1'b0, ce_r}) begin
          c_nxt     = c_r + 1'b1;
          addr_nxt  = addr_r + AW'(1);
          state_nxt = sps_pkg::ST_RD_CTR;
        end else if ({1'b0, r_r} + 1'b1 < {1'b0, re_r}) begin
          r_nxt     = r_r + 1'b1;
          c_nxt     = cs_r;
          addr_nxt  = addr_of(r_r + 1'b1, cs_r);
          state_nxt = sps_pkg::ST_RD_CTR;
        end else begin
          state_nxt = sps_pkg::ST_DONE;
        end
      end
      sps_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = sps_pkg::ST_IDLE;
      end
      default: state_nxt = sps_pkg::ST_IDLE;
    endcase
  end

  assign res.read_value = rd_r;
  assign res.changed    = any_r;

endmodule

// ----- rtl/core/sandpile_topple_sweep.sv -----
// Sandpile toppling engine over a GRID_SIDE x GRID_SIDE grid of 32-bit counts.
// Requests arrive on in_valid/in_ready/in_data, one result per request leaves
// on out_valid/out_ready/out_data. Mode load writes one cell, mode read returns
// one cell, mode sweep topples a clamped window in row-major order in place and
// reports whether any cell toppled.
// One request is handled at a time; in_ready is high only while idle.
// Every grid access goes through the single port of the grid memory. A load
//   writes its cell, a read reads it, an out-of-grid cell or unused mode touches
//   nothing; a sweep reads each window cell and, if it topples, writes back the
//   remainder, then reads and updates each of its four neighbours in turn.
// The sequencer is idle in the same cycle as its result enters the output
// register, so it takes no new request before the last result has left it.
// The result is held in an output register; the next request is taken while
// it waits, and the sequencer holds its finished result until the register
// frees up, so a stalled receiver stops the block without losing anything.
// Reset clears control state only; grid contents are undefined until loaded.
module sandpile_topple_sweep #(
  parameter int GRID_SIDE = sps_pkg::GRID_SIDE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sps_pkg::out_item_t out_data
);

  logic               idle, res_valid, res_ready;
  sps_pkg::out_item_t res;
  logic               out_valid_r;
  sps_pkg::out_item_t out_data_r;

  sps_ctrl #(.GRID_SIDE(GRID_SIDE)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && idle),
    .item      (in_data),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign in_ready  = idle;
  assign res_ready = !out_valid_r || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
